// ===== hw/rtl/bbcrr_pkg.sv =====
// Shared types and codes of the block buffer claim unit.
`timescale 1ns / 1ps

package bbcrr_pkg;

	localparam logic MODE_CLAIM   = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [31:0] block_number;
		logic [4:0]  release_index;
	} request_t;

	typedef struct packed {
		logic [4:0] buffer_index;
		logic       hit;
		logic       forced_flush;
		logic       already_locked;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;  // register the request and the tag match vector
		logic commit;   // pick the entry, update state, register the result
	} dp_cmd_t;

endpackage

// ===== hw/rtl/bbcrr_ctrl.sv =====
// Controller of the block buffer claim unit: accept, commit and result strobe.
`timescale 1ns / 1ps

module bbcrr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	output bbcrr_pkg::dp_cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	assign busy        = busy_q;
	assign done        = done_q;
	assign cmd.capture = start && !busy_q;
	assign cmd.commit  = (state_q == ST_COMMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						state_q <= ST_COMMIT;
						busy_q  <= 1'b1;
					end
				end
				ST_COMMIT: begin
					// the result register loads at this edge; strobe it next cycle
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	a_commit_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy && done)
		else $error("commit did not finish in one cycle with a result strobe");

	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !done)
		else $error("result strobe without a committed request");

	a_busy_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		busy == cmd.commit)
		else $error("busy flag out of step with commit state");

endmodule

// ===== hw/rtl/bbcrr_datapath.sv =====
// Datapath of the block buffer claim unit: tags, valid and lock bits, round-robin pick.
`timescale 1ns / 1ps

module bbcrr_datapath #(
	parameter int NUM_BUFFERS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bbcrr_pkg::dp_cmd_t  cmd,
	input  bbcrr_pkg::request_t request,
	output bbcrr_pkg::result_t  result
);

	localparam int IDX_W = $clog2(NUM_BUFFERS);
	localparam logic [IDX_W:0] NUM_W = (IDX_W + 1)'(NUM_BUFFERS);

	logic [31:0]            tags_q [NUM_BUFFERS];
	logic [NUM_BUFFERS-1:0] valid_q;
	logic [NUM_BUFFERS-1:0] locked_q;
	logic [IDX_W-1:0]       next_pick_q;

	bbcrr_pkg::request_t    req_s1;
	logic [NUM_BUFFERS-1:0] match_s1;
	bbcrr_pkg::result_t     result_q;

	// commit-cycle decode
	logic                   is_release;
	logic [IDX_W-1:0]       rel_idx;
	logic                   rel_in_range;
	logic                   hit_found;
	logic [IDX_W-1:0]       hit_idx;
	logic                   any_free;
	logic [IDX_W-1:0]       pick_idx;
	logic [IDX_W-1:0]       pick_next;
	logic [IDX_W-1:0]       chosen;
	logic                   do_flush;
	logic                   do_retag;

	assign result = result_q;

	// Capture: compare every valid tag against the incoming block number.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_s1 <= request;
			for (int i = 0; i < NUM_BUFFERS; i++) begin
				match_s1[i] <= valid_q[i] && (tags_q[i] == request.block_number);
			end
		end
	end

	always_comb begin
		logic [2*NUM_BUFFERS-1:0] free2;
		logic [NUM_BUFFERS-1:0]   rot;
		logic [IDX_W-1:0]         off;
		logic [IDX_W:0]           sum;
		logic [IDX_W:0]           nsum;

		is_release   = (req_s1.mode == bbcrr_pkg::MODE_RELEASE);
		rel_idx      = IDX_W'(req_s1.release_index);
		rel_in_range = (32'(req_s1.release_index) < NUM_BUFFERS);

		// highest matching index wins
		hit_found = |match_s1;
		hit_idx   = '0;
		for (int i = 0; i < NUM_BUFFERS; i++) begin
			if (match_s1[i]) hit_idx = IDX_W'(i);
		end

		// first unlocked entry at or after the pointer, wrapping around
		any_free = ~&locked_q;
		free2    = {~locked_q, ~locked_q} >> next_pick_q;
		rot      = free2[NUM_BUFFERS-1:0];
		off      = '0;
		for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
			if (rot[i]) off = IDX_W'(i);
		end
		sum = {1'b0, next_pick_q} + {1'b0, off};
		if (sum >= NUM_W) sum = sum - NUM_W;
		pick_idx = sum[IDX_W-1:0];
		nsum     = {1'b0, pick_idx} + (IDX_W + 1)'(1);
		if (nsum == NUM_W) nsum = '0;
		pick_next = nsum[IDX_W-1:0];

		do_flush = !is_release && !hit_found && !any_free;
		do_retag = !is_release && !hit_found;
		if (hit_found)     chosen = hit_idx;
		else if (any_free) chosen = pick_idx;
		else               chosen = '0;
	end

	// Tags: retag the chosen entry on a miss.
	always_ff @(posedge clk) begin
		if (cmd.commit && do_retag) begin
			tags_q[chosen] <= req_s1.block_number;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			locked_q    <= '0;
			next_pick_q <= '0;
		end else if (cmd.commit) begin
			if (is_release) begin
				if (rel_in_range) locked_q[rel_idx] <= 1'b0;
			end else if (do_flush) begin
				// every entry locked: drop them all and restart at entry 0
				valid_q     <= NUM_BUFFERS'(1);
				locked_q    <= NUM_BUFFERS'(1);
				next_pick_q <= IDX_W'(1);
			end else begin
				locked_q[chosen] <= 1'b1;
				if (!hit_found) begin
					valid_q[chosen] <= 1'b1;
					next_pick_q     <= pick_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (is_release) begin
				result_q.buffer_index   <= req_s1.release_index;
				result_q.hit            <= 1'b0;
				result_q.forced_flush   <= 1'b0;
				result_q.already_locked <= 1'b0;
			end else begin
				result_q.buffer_index   <= 5'(chosen);
				result_q.hit            <= hit_found;
				result_q.forced_flush   <= do_flush;
				result_q.already_locked <= hit_found && locked_q[hit_idx];
			end
		end
	end

endmodule

// ===== hw/rtl/block_buffer_claim_round_robin_unit.sv =====
// Top level of the block buffer claim unit: controller plus datapath.
`timescale 1ns / 1ps

// Tag manager for a disk block buffer cache with round-robin replacement.
// Request channel: drive request and raise start; the transfer happens at a
// rising edge where start is high and busy is low. mode selects a claim of
// a buffer for block_number or a release of the entry release_index.
// Result channel: done is high for exactly one cycle while result holds the
// transfer (buffer_index, hit, forced_flush, already_locked); the receiver
// cannot stall it and must take it in that cycle.
// Each request passes a capture step and then a commit step. The capture step
// compares all tags in parallel and registers the match vector; the commit step
// runs the highest match and round-robin free-entry pick, updates tags, valid and
// lock bits and registers the result, which done then strobes. busy is high in
// the commit step only, so no new request is taken while one commits, yet a new
// request may transfer in the same cycle its predecessor's result is strobed,
// and it sees the updated state.
// Reset (arst_n low): all entries invalid and unlocked, pointer at 0, no
// result pending. No clearing pass is needed; requests are taken at once.
module block_buffer_claim_round_robin_unit #(
	parameter int NUM_BUFFERS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  bbcrr_pkg::request_t request,
	output logic                busy,
	output logic                done,
	output bbcrr_pkg::result_t  result
);

	bbcrr_pkg::dp_cmd_t cmd;

	// Sequence the capture and commit steps of each request.
	bbcrr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// Hold the cache state and compute each result.
	bbcrr_datapath #(
		.NUM_BUFFERS (NUM_BUFFERS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.request (request),
		.result  (result)
	);

endmodule

// ===== bench/bbcrr_tb_pkg.sv =====
// Scoreboard class: predicts claim and release results of the buffer claim unit.
`timescale 1ns / 1ps

package bbcrr_tb_pkg;

	localparam int ENTRIES = 32;

	class claim_scoreboard;
		logic [31:0]          tag_of [ENTRIES];
		bit                   valid  [ENTRIES];
		bit                   locked [ENTRIES];
		int unsigned          rr_ptr;
		bbcrr_pkg::result_t   awaited [$];
		int unsigned          errors;
		int unsigned          claims;
		int unsigned          hits;
		int unsigned          locked_hits;
		int unsigned          flushes;
		int unsigned          releases;

		function new();
			foreach (tag_of[i]) begin
				tag_of[i] = '0;
				valid[i]  = 1'b0;
				locked[i] = 1'b0;
			end
			rr_ptr      = 0;
			errors      = 0;
			claims      = 0;
			hits        = 0;
			locked_hits = 0;
			flushes     = 0;
			releases    = 0;
		endfunction

		// Advance the cache state by one accepted request and queue its result.
		function void note_request(bbcrr_pkg::request_t req);
			bbcrr_pkg::result_t exp;
			int      pick;
			int      p;
			int      i;
			bit      found;
			exp   = '0;
			pick  = 0;
			found = 1'b0;
			if (req.mode == bbcrr_pkg::MODE_RELEASE) begin
				if (req.release_index < ENTRIES)
					locked[req.release_index] = 1'b0;
				exp.buffer_index = req.release_index;
				releases++;
			end else begin
				claims++;
				// highest matching valid entry wins
				for (i = 0; i < ENTRIES; i++)
					if (valid[i] && tag_of[i] == req.block_number) begin
						pick  = i;
						found = 1'b1;
					end
				if (found) begin
					exp.hit            = 1'b1;
					exp.already_locked = locked[pick];
					hits++;
					if (locked[pick])
						locked_hits++;
				end else begin
					p = rr_ptr;
					for (i = 0; i < ENTRIES && !found; i++) begin
						if (!locked[p]) begin
							pick  = p;
							found = 1'b1;
						end
						p = (p + 1) % ENTRIES;
					end
					if (found) begin
						rr_ptr = p;
					end else begin
						foreach (valid[k]) begin
							valid[k]  = 1'b0;
							locked[k] = 1'b0;
						end
						pick             = 0;
						rr_ptr           = 1 % ENTRIES;
						exp.forced_flush = 1'b1;
						flushes++;
					end
					tag_of[pick] = req.block_number;
					valid[pick]  = 1'b1;
				end
				locked[pick]     = 1'b1;
				exp.buffer_index = pick[4:0];
			end
			awaited.push_back(exp);
		endfunction

		// Compare one strobed result against the oldest queued prediction.
		function void check_result(bbcrr_pkg::result_t got);
			bbcrr_pkg::result_t exp;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result idx %0d hit %0b flush %0b locked %0b",
					$time, got.buffer_index, got.hit, got.forced_flush, got.already_locked);
				errors++;
				return;
			end
			exp = awaited.pop_front();
			if (got.buffer_index !== exp.buffer_index || got.hit !== exp.hit ||
			    got.forced_flush !== exp.forced_flush ||
			    got.already_locked !== exp.already_locked) begin
				$display("%0t: mismatch expected idx %0d hit %0b flush %0b locked %0b",
					$time, exp.buffer_index, exp.hit, exp.forced_flush, exp.already_locked);
				$display("%0t:          actual idx %0d hit %0b flush %0b locked %0b",
					$time, got.buffer_index, got.hit, got.forced_flush, got.already_locked);
				errors++;
			end
		endfunction

		function void flag_leftover();
			if (awaited.size() != 0) begin
				$display("%0t: %0d results never arrived", $time, awaited.size());
				errors += awaited.size();
			end
		endfunction
	endclass

endpackage

// ===== bench/tb_top.sv =====
// Testbench top: drives claims and releases into the buffer claim unit and checks results.
`timescale 1ns / 1ps

module tb_top;

	logic                clk     = 1'b0;
	logic                arst_n  = 1'b0;
	logic                start   = 1'b0;
	bbcrr_pkg::request_t request = '0;
	logic                busy;
	logic                done;
	bbcrr_pkg::result_t  result;

	bbcrr_tb_pkg::claim_scoreboard board = new();

	int unsigned sent   = 0;
	bit          steady = 1'b0;  // when set, no gaps between transfers

	block_buffer_claim_round_robin_unit #(
		.NUM_BUFFERS(bbcrr_tb_pkg::ENTRIES)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.request(request),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The result strobe cannot be held off: take every strobed result at the
	// edge that closes its cycle.
	always @(posedge clk) begin
		if (arst_n && done)
			board.check_result(result);
	end

	// Hard stop in case the unit hangs.
	initial begin
		#5_000_000;
		$display("tb_top: errors");
		$finish;
	end

	// Mostly back-to-back or short gaps, now and then a long pause.
	function automatic int gap_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic bbcrr_pkg::request_t claim_of(logic [31:0] blk);
		bbcrr_pkg::request_t req;
		req               = '0;
		req.mode          = bbcrr_pkg::MODE_CLAIM;
		req.block_number  = blk;
		// the unused field carries noise that must not matter
		req.release_index = 5'($urandom_range(0, 31));
		return req;
	endfunction

	function automatic bbcrr_pkg::request_t release_of(logic [4:0] idx);
		bbcrr_pkg::request_t req;
		req               = '0;
		req.mode          = bbcrr_pkg::MODE_RELEASE;
		req.block_number  = $urandom;
		req.release_index = idx;
		return req;
	endfunction

	// Present one request, hold start until the transfer edge, then note it
	// and maybe drop start for a while with junk on the request bus.
	task automatic transfer(input bbcrr_pkg::request_t req);
		int          gap;
		logic [63:0] noise;
		request <= req;
		start   <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		board.note_request(req);
		sent++;
		gap = gap_length();
		if (gap > 0) begin
			noise   = {$urandom, $urandom};
			start   <= 1'b0;
			request <= noise[$bits(bbcrr_pkg::request_t)-1:0];
			repeat (gap) @(posedge clk);
		end
	endtask

	// Claims from a small pool of block numbers, so hits, locked hits and
	// stale tags after a flush come up often; release share varies per burst.
	task automatic mixed_burst();
		logic [31:0] pool [8];
		int          len;
		int          rel_pct;
		int          n;
		len = $urandom_range(10, 60);
		case ($urandom_range(0, 2))
			0: rel_pct = 5;
			1: rel_pct = 25;
			default: rel_pct = 50;
		endcase
		foreach (pool[k])
			pool[k] = $urandom;
		pool[0] = ($urandom_range(0, 1) == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
		for (n = 0; n < len; n++) begin
			if ($urandom_range(0, 99) < rel_pct)
				transfer(release_of(5'($urandom_range(0, 31))));
			else if ($urandom_range(0, 4) != 0)
				transfer(claim_of(pool[3'($urandom_range(0, 7))]));
			else
				transfer(claim_of($urandom));
		end
	endtask

	// Fresh blocks with no releases: every entry ends up locked, which forces
	// a flush before the burst is over.
	task automatic fill_burst();
		int n;
		for (n = 0; n < bbcrr_tb_pkg::ENTRIES + 2; n++)
			transfer(claim_of($urandom));
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: tag zero must not hit before it is written, then hit,
		// locked hit, release and re-claim, extremes of the block number,
		// release of an unlocked entry, hit on an unlocked entry.
		steady = 1'b0;
		transfer(claim_of(32'h0000_0000));
		transfer(claim_of(32'h0000_0000));
		transfer(release_of(5'd0));
		transfer(claim_of(32'h0000_0000));
		transfer(claim_of(32'hFFFF_FFFF));
		transfer(claim_of(32'h8000_0000));
		transfer(claim_of(32'h0000_0001));
		transfer(release_of(5'd31));
		transfer(release_of(5'd1));
		transfer(claim_of(32'hFFFF_FFFF));
		transfer(claim_of(32'hFFFF_FFFF));
		steady = 1'b1;
		transfer(claim_of(32'h5555_5555));
		transfer(claim_of(32'hAAAA_AAAA));
		transfer(release_of(5'd2));
		transfer(release_of(5'd3));
		transfer(claim_of(32'hAAAA_AAAA));
		transfer(claim_of(32'h7FFF_FFFF));
		transfer(release_of(5'h15));
		transfer(release_of(5'h0A));

		// Random bursts until about 750 requests have gone in.
		while (sent < 750) begin
			steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 3) == 0)
				fill_burst();
			else
				mixed_burst();
		end
		start <= 1'b0;

		// Drain, then give a late or extra strobe time to show up.
		while (board.awaited.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		board.flag_leftover();

		$display("summary: %0d requests, %0d claims (%0d hits, %0d on locked entries)",
			sent, board.claims, board.hits, board.locked_hits);
		$display("summary: %0d forced flushes, %0d releases, %0d failures",
			board.flushes, board.releases, board.errors);
		if (board.errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/bbcrr_pkg.sv
hw/rtl/bbcrr_ctrl.sv
hw/rtl/bbcrr_datapath.sv
hw/rtl/block_buffer_claim_round_robin_unit.sv
bench/bbcrr_tb_pkg.sv
bench/tb_top.sv
